FILE: hdl/per_source_rate_spike_tracker_unit_assert.svh
// Assertion macros for the rate spike tracker
`ifndef PER_SOURCE_RATE_SPIKE_TRACKER_UNIT_ASSERT_SVH
`define PER_SOURCE_RATE_SPIKE_TRACKER_UNIT_ASSERT_SVH
`define PSRST_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PSRST_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: hdl/psrst_pkg.sv
// ------------------------------------------------------------------------
// psrst_pkg
// Shared types and constants of the per-source rate spike tracker.
// ------------------------------------------------------------------------
package psrst_pkg;
    localparam int TABLE_SLOTS = 4096;
    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = 16;
    localparam int ENTRY_W = 32 + CNT_W + 32;

    localparam logic [2:0] OUT_FILTERED  = 3'd0;
    localparam logic [2:0] OUT_INSERTED  = 3'd1;
    localparam logic [2:0] OUT_COUNTED   = 3'd2;
    localparam logic [2:0] OUT_RESTARTED = 3'd3;
    localparam logic [2:0] OUT_FULL      = 3'd4;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WINDOW    = 2'd1;
    localparam logic [1:0] REG_EVICT     = 2'd2;

    typedef enum logic [2:0] {
        t_ST_IDLE, t_ST_HASH, t_ST_MOD, t_ST_READ, t_ST_CHECK, t_ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0]      source;
        logic [CNT_W-1:0] count;
        logic [31:0]      start;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr;
endpackage

FILE: hdl/per_source_rate_spike_tracker_unit.sv
// ------------------------------------------------------------------------
// per_source_rate_spike_tracker_unit
// Per-source packet rate tracker over an open-addressed, linearly probed
// slot table.
// ------------------------------------------------------------------------
// Throughput: one item at a time; the probe loop through the table's
// single read port sets the rate.
// Reset: synchronous, active low; then a valid clearing sweep over all
// 4096 slots, during which no item is accepted.
module per_source_rate_spike_tracker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [31:0] i_now_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_alert,
    output logic [2:0]  o_outcome
);
    localparam int IW = psrst_pkg::IDX_W;

    psrst_pkg::t_state r_st, n_st;
    logic [15:0] r_thr;
    logic [7:0]  r_win;
    logic [15:0] r_evict;
    logic [31:0] r_src, r_dst, r_now;
    logic [IW-1:0] r_home, r_idx, n_idx;
    logic [31:0] r_mod;
    logic r_alert, n_alert;
    logic [2:0] r_outc, n_outc;
    logic r_ovalid;
    logic hstart, hdone;
    logic [31:0] hval;
    psrst_pkg::t_entry rdata;
    psrst_pkg::t_wr wr;
    logic rvalid, tready, filt, accept;
    logic [31:0] age;
    logic [psrst_pkg::CNT_W-1:0] inc;

    psrst_hash u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(hstart),
        .i_addr(i_source_address), .o_done(hdone), .o_hash(hval)
    );

    psrst_table u_table (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_raddr(r_idx), .i_wr(wr),
        .o_rdata(rdata), .o_rvalid(rvalid), .o_ready(tready)
    );

    assign o_ready = (r_st == psrst_pkg::t_ST_IDLE) && tready && !r_ovalid;
    assign accept = i_valid && o_ready;
    assign filt = (r_src == 32'h7F000001) || (r_src[31:16] == 16'hAC12)
        || (r_dst[31:16] == 16'hAC12);
    assign age = r_now - rdata.start;
    assign inc = (rdata.count == '1) ? rdata.count : rdata.count + 1'b1;

    always_comb begin
        n_st = r_st;
        case (r_st)
            psrst_pkg::t_ST_IDLE: if (accept) n_st = psrst_pkg::t_ST_HASH;
            psrst_pkg::t_ST_HASH: begin
                if (filt) n_st = psrst_pkg::t_ST_OUT;
                else if (hdone) n_st = psrst_pkg::t_ST_MOD;
            end
            psrst_pkg::t_ST_MOD: n_st = psrst_pkg::t_ST_READ;
            psrst_pkg::t_ST_READ: n_st = psrst_pkg::t_ST_CHECK;
            psrst_pkg::t_ST_CHECK: begin
                if (!rvalid || rdata.source == r_src || age > {16'd0, r_evict}
                    || n_idx == r_home) n_st = psrst_pkg::t_ST_OUT;
                else n_st = psrst_pkg::t_ST_READ;
            end
            psrst_pkg::t_ST_OUT: n_st = psrst_pkg::t_ST_IDLE;
            default: n_st = psrst_pkg::t_ST_IDLE;
        endcase
    end

    always_comb begin
        hstart = accept;
        n_idx = (r_idx == IW'(psrst_pkg::TABLE_SLOTS - 1)) ? '0 : r_idx + 1'b1;
        n_alert = r_alert;
        n_outc = r_outc;
        wr = '0;
        wr.addr = r_idx;
        wr.data.source = r_src;
        wr.data.count = 16'd1;
        wr.data.start = r_now;
        case (r_st)
            psrst_pkg::t_ST_CHECK: begin
                if (!rvalid || (rdata.source != r_src && age > {16'd0, r_evict})) begin
                    wr.we = 1'b1;
                    n_outc = psrst_pkg::OUT_INSERTED;
                end else if (rdata.source == r_src) begin
                    wr.we = 1'b1;
                    if (age > {24'd0, r_win}) begin
                        n_outc = psrst_pkg::OUT_RESTARTED;
                    end else begin
                        wr.data.count = inc;
                        wr.data.start = rdata.start;
                        n_alert = inc > r_thr;
                        n_outc = psrst_pkg::OUT_COUNTED;
                    end
                end else if (n_idx == r_home) begin
                    n_outc = psrst_pkg::OUT_FULL;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= psrst_pkg::t_ST_IDLE;
            r_ovalid <= 1'b0;
            r_thr <= 16'd1000;
            r_win <= 8'd1;
            r_evict <= 16'd10;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    psrst_pkg::REG_THRESHOLD: r_thr <= i_cfg_data;
                    psrst_pkg::REG_WINDOW: r_win <= i_cfg_data[7:0];
                    psrst_pkg::REG_EVICT: r_evict <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_st == psrst_pkg::t_ST_OUT) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src <= i_source_address;
            r_dst <= i_dest_address;
            r_now <= i_now_seconds;
            r_alert <= 1'b0;
            r_outc <= psrst_pkg::OUT_FILTERED;
        end else begin
            r_alert <= n_alert;
            r_outc <= n_outc;
        end
        if (r_st == psrst_pkg::t_ST_HASH) r_mod <= hval;
        if (r_st == psrst_pkg::t_ST_MOD) begin
            r_home <= IW'(r_mod % psrst_pkg::TABLE_SLOTS);
            r_idx <= IW'(r_mod % psrst_pkg::TABLE_SLOTS);
        end else if (r_st == psrst_pkg::t_ST_CHECK) begin
            r_idx <= n_idx;
        end
    end

    assign o_valid = r_ovalid;
    assign o_alert = r_alert;
    assign o_outcome = r_outc;

`include "per_source_rate_spike_tracker_unit_assert.svh"

    `PSRST_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_st != psrst_pkg::t_ST_IDLE, !o_ready)
    `PSRST_ASSERT_IMPL(a_alert_counted, i_clk, i_rst_n, o_valid && o_alert, o_outcome == psrst_pkg::OUT_COUNTED)
    `PSRST_ASSERT_NEXT(a_out_valid, i_clk, i_rst_n, r_st == psrst_pkg::t_ST_OUT, o_valid)
endmodule

FILE: hdl/psrst_hash.sv
// ------------------------------------------------------------------------
// psrst_hash
// Sequential djb2 hash over the dotted-decimal text of an address, one
// octet per cycle.
// ------------------------------------------------------------------------
module psrst_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_addr,
    output logic        o_done,
    output logic [31:0] o_hash
);
    logic [31:0] r_hash, n_hash;
    logic [31:0] r_addr;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic [7:0]  v;
    logic [3:0]  d2, d1, d0;
    logic [7:0]  rem;
    logic [15:0] prod;
    logic [7:0]  tens, ones;

    function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] c);
        mix = (h << 5) + h + {24'd0, c};
    endfunction

    always_comb begin
        v = r_addr[31:24];
        d2 = (v >= 8'd200) ? 4'd2 : (v >= 8'd100) ? 4'd1 : 4'd0;
        rem = v - ((v >= 8'd200) ? 8'd200 : (v >= 8'd100) ? 8'd100 : 8'd0);
        prod = {8'd0, rem} * 16'd205;
        d1 = prod[14:11];
        tens = {1'b0, d1, 3'b000} + {3'b000, d1, 1'b0};
        ones = rem - tens;
        d0 = ones[3:0];
        n_hash = r_hash;
        if (r_cnt != 3'd0) n_hash = mix(n_hash, 8'h2E);
        if (v >= 8'd100) n_hash = mix(n_hash, 8'h30 + {4'd0, d2});
        if (v >= 8'd10) n_hash = mix(n_hash, 8'h30 + {4'd0, d1});
        n_hash = mix(n_hash, 8'h30 + {4'd0, d0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= 3'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= 3'd0;
            r_hash <= 32'd5381;
            r_addr <= i_addr;
        end else if (r_busy && r_cnt != 3'd4) begin
            r_hash <= n_hash;
            r_addr <= {r_addr[23:0], 8'd0};
            r_cnt <= r_cnt + 3'd1;
        end
    end

    assign o_done = r_busy && (r_cnt == 3'd4);
    assign o_hash = r_hash;
endmodule

FILE: hdl/psrst_table.sv
// ------------------------------------------------------------------------
// psrst_table
// Slot store: entry memory with registered read, valid bits in a memory
// cleared by a sweep after reset.
// ------------------------------------------------------------------------
module psrst_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [psrst_pkg::IDX_W-1:0] i_raddr,
    input  psrst_pkg::t_wr              i_wr,
    output psrst_pkg::t_entry           o_rdata,
    output logic                        o_rvalid,
    output logic                        o_ready
);
    psrst_pkg::t_entry r_mem [psrst_pkg::TABLE_SLOTS];
    logic r_vmem [psrst_pkg::TABLE_SLOTS];
    logic [psrst_pkg::IDX_W:0] r_clr;
    logic vwe, vdat;
    logic [psrst_pkg::IDX_W-1:0] vaddr;

    assign o_ready = r_clr[psrst_pkg::IDX_W];
    assign vwe = !o_ready || i_wr.we;
    assign vaddr = o_ready ? i_wr.addr : r_clr[psrst_pkg::IDX_W-1:0];
    assign vdat = o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (!o_ready) r_clr <= r_clr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) r_mem[i_wr.addr] <= i_wr.data;
        o_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (vwe) r_vmem[vaddr] <= vdat;
        o_rvalid <= r_vmem[i_raddr];
    end
endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// tb
// Self-checking bench for the per-source rate spike tracker: directed
// items for filtering, insert, count, alert, window restart, time wrap,
// a long count run and a densely filled table with eviction, then random
// packets over a small source pool under several register settings, with
// random idling on both channels. A local slot-table model predicts every
// result.
// ------------------------------------------------------------------------
module tb;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic       alert;
        logic [2:0] outcome;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_source_address;
    logic [31:0] i_dest_address;
    logic [31:0] i_now_seconds;
    logic        o_valid;
    logic        i_ready;
    logic        o_alert;
    logic [2:0]  o_outcome;

    bit          slot_used [psrst_pkg::TABLE_SLOTS];
    logic [31:0] slot_src [psrst_pkg::TABLE_SLOTS];
    logic [15:0] slot_cnt [psrst_pkg::TABLE_SLOTS];
    logic [31:0] slot_start [psrst_pkg::TABLE_SLOTS];
    logic [15:0] threshold_reg;
    logic [7:0]  window_reg;
    logic [15:0] evict_reg;

    t_verdict    pending_verdicts[$];
    int          fail_count;
    int          cycle_count;
    bit          calm;
    logic [31:0] clock_now;
    logic [31:0] source_pool [48];

    per_source_rate_spike_tracker_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] dotted_hash(logic [31:0] addr);
        logic [31:0] h;
        int          v;
        h = 32'd5381;
        for (int o = 0; o < 4; o++) begin
            v = addr[31 - 8 * o -: 8];
            if (o != 0) h = h * 33 + 46;
            if (v >= 100) h = h * 33 + 48 + v / 100;
            if (v >= 10) h = h * 33 + 48 + (v / 10) % 10;
            h = h * 33 + 48 + v % 10;
        end
        return h;
    endfunction

    function automatic bit is_filtered(logic [31:0] src, logic [31:0] dst);
        return src == 32'h7F000001 || src[31:16] == 16'hAC12 || dst[31:16] == 16'hAC12;
    endfunction

    function automatic t_verdict track_packet(logic [31:0] src, logic [31:0] dst,
                                              logic [31:0] now);
        t_verdict    r;
        int          home;
        int          idx;
        logic [31:0] age;
        r.alert = 1'b0;
        r.outcome = psrst_pkg::OUT_FILTERED;
        if (is_filtered(src, dst)) return r;
        home = dotted_hash(src) % psrst_pkg::TABLE_SLOTS;
        idx = home;
        r.outcome = psrst_pkg::OUT_INSERTED;
        while (slot_used[idx]) begin
            age = now - slot_start[idx];
            if (slot_src[idx] == src) begin
                if (age > window_reg) begin
                    slot_cnt[idx] = 16'd1;
                    slot_start[idx] = now;
                    r.outcome = psrst_pkg::OUT_RESTARTED;
                end else begin
                    if (slot_cnt[idx] != 16'hFFFF) slot_cnt[idx]++;
                    r.alert = slot_cnt[idx] > threshold_reg;
                    r.outcome = psrst_pkg::OUT_COUNTED;
                end
                break;
            end
            if (age > evict_reg) break;
            idx = (idx + 1) % psrst_pkg::TABLE_SLOTS;
            if (idx == home) begin
                r.outcome = psrst_pkg::OUT_FULL;
                break;
            end
        end
        if (r.outcome == psrst_pkg::OUT_INSERTED) begin
            slot_used[idx] = 1'b1;
            slot_src[idx] = src;
            slot_cnt[idx] = 16'd1;
            slot_start[idx] = now;
        end
        return r;
    endfunction

    task automatic send_packet(logic [31:0] src, logic [31:0] dst, logic [31:0] now);
        while (!calm && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_source_address <= src;
        i_dest_address <= dst;
        i_now_seconds <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_verdicts.push_back(track_packet(src, dst, now));
    endtask

    task automatic drain;
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            psrst_pkg::REG_THRESHOLD: threshold_reg = value;
            psrst_pkg::REG_WINDOW:    window_reg = value[7:0];
            psrst_pkg::REG_EVICT:     evict_reg = value;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] thr, logic [7:0] win, logic [15:0] evict);
        drain();
        write_reg(psrst_pkg::REG_THRESHOLD, thr);
        write_reg(psrst_pkg::REG_WINDOW, {8'd0, win});
        write_reg(psrst_pkg::REG_EVICT, evict);
    endtask

    task automatic test_filtering;
        set_regs(16'd2, 8'd3, 16'd5);
        send_packet(32'h7F000001, 32'h01020304, 32'd50);
        send_packet(32'hAC120505, 32'h01020304, 32'd50);
        send_packet(32'h0B000001, 32'hAC120001, 32'd50);
        send_packet(32'h7F000002, 32'hAC130001, 32'd50);
        send_packet(32'hAC130000, 32'h00000000, 32'd50);
        send_packet(32'h00000000, 32'h00000000, 32'd0);
        send_packet(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    endtask

    task automatic test_count_and_restart;
        send_packet(32'h0A010203, 32'h08080808, 32'd100);
        send_packet(32'h0A010203, 32'h08080808, 32'd101);
        send_packet(32'h0A010203, 32'h08080808, 32'd102);
        send_packet(32'h0A010203, 32'h08080808, 32'd104);
        send_packet(32'h0A010203, 32'h08080808, 32'd103);
        send_packet(32'h0A010203, 32'h08080808, 32'd103);
        send_packet(32'hC0A80001, 32'h08080808, 32'hFFFFFFFF);
        send_packet(32'hC0A80001, 32'h08080808, 32'd2);
        send_packet(32'hC0A80001, 32'h08080808, 32'd6);
    endtask

    task automatic test_zero_threshold;
        set_regs(16'd0, 8'd0, 16'd0);
        send_packet(32'h64646464, 32'h01010101, 32'd500);
        send_packet(32'h64646464, 32'h01010101, 32'd500);
        send_packet(32'h64646464, 32'h01010101, 32'd501);
        send_packet(32'h0A010203, 32'h01010101, 32'd500);
    endtask

    task automatic test_long_count;
        set_regs(16'd100, 8'd255, 16'd65535);
        calm = 1'b1;
        for (int n = 0; n < 120; n++)
            send_packet(32'hC6336407, 32'h02020202, 32'd9000);
        calm = 1'b0;
    endtask

    task automatic random_phase(int items);
        logic [31:0] src;
        logic [31:0] dst;
        int          pick;
        for (int n = 0; n < items; n++) begin
            src = source_pool[$urandom_range(47)];
            pick = $urandom_range(99);
            if (pick < 4) src = 32'h7F000001;
            else if (pick < 8) src = {16'hAC12, 16'($urandom)};
            else if (pick < 11) src = $urandom;
            dst = $urandom;
            if ($urandom_range(99) < 6) dst[31:16] = 16'hAC12;
            pick = $urandom_range(99);
            if (pick < 5) clock_now += $urandom_range(400);
            else if (pick < 7) clock_now -= $urandom_range(300);
            else if (pick < 8) clock_now = $urandom;
            else clock_now += $urandom_range(2);
            send_packet(src, dst, clock_now);
        end
    endtask

    task automatic test_random_traffic;
        for (int k = 0; k < 48; k++) begin
            do source_pool[k] = $urandom;
            while (is_filtered(source_pool[k], 32'd0));
        end
        clock_now = $urandom;
        set_regs(16'd3, 8'd4, 16'd20);
        random_phase(250);
        set_regs(16'd0, 8'd0, 16'd0);
        calm = 1'b1;
        random_phase(250);
        calm = 1'b0;
        set_regs(16'd65534, 8'd255, 16'd65535);
        random_phase(250);
        set_regs(16'($urandom_range(8)), 8'($urandom_range(10)), 16'($urandom_range(60)));
        random_phase(250);
    endtask

    task automatic test_dense_table;
        set_regs(16'd5, 8'd255, 16'd65535);
        clock_now += 32'd1000000;
        for (int n = 0; n < 100; n++)
            send_packet(32'h0A000000 + 32'(n), 32'h05050505, clock_now);
        for (int n = 0; n < 60; n++)
            send_packet(32'h0A000000 + 32'((n * 3) % 100), 32'h05050505, clock_now);
        send_packet(32'h0B000000, 32'h05050505, clock_now);
        send_packet(32'h0B0000FF, 32'h05050505, clock_now);
        send_packet(32'h0A000007, 32'h05050505, clock_now);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= calm || $urandom_range(99) >= 22;
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: alert %0d outcome %0d", o_alert, o_outcome);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_alert !== want.alert) begin
                    $error("alert: expected %0d actual %0d", want.alert, o_alert);
                    fail_count++;
                end
                if (o_outcome !== want.outcome) begin
                    $error("outcome: expected %0d actual %0d", want.outcome, o_outcome);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("per_source_rate_spike_tracker_unit verification failed");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
        fail_count = 0;
        calm = 1'b0;
        threshold_reg = 16'd1000;
        window_reg = 8'd1;
        evict_reg = 16'd10;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = psrst_pkg::REG_THRESHOLD;
        i_cfg_data = 16'd0;
        i_valid = 1'b0;
        i_source_address = 32'd0;
        i_dest_address = 32'd0;
        i_now_seconds = 32'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_filtering();
        test_count_and_restart();
        test_zero_threshold();
        test_long_count();
        test_random_traffic();
        test_dense_table();
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("per_source_rate_spike_tracker_unit verification clean");
        else
            $display("per_source_rate_spike_tracker_unit verification failed");
        $finish;
    end
endmodule
